// ----- src/waveform_peak_decimator_defines.svh -----
// Assertion macros shared by the peak decimator RTL.
`ifndef WAVEFORM_PEAK_DECIMATOR_DEFINES_SVH
`define WAVEFORM_PEAK_DECIMATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WPD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define WPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/wpd_pkg.sv -----
// Shared types, widths and constants of the waveform peak decimator.
package wpd_pkg;

  // Fixed field widths of the configuration registers
  localparam int COUNT_W        = 24;
  localparam int COLS_W         = 13;
  localparam int GAIN_W         = 16;
  localparam int AREA_W         = 12;
  localparam int GRID_W         = 9;
  localparam int ROWCALC_W      = 13;
  localparam int GAIN_FRAC_BITS = 8;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // Defaults for the top level parameters
  localparam int SAMPLE_BITS_DEFAULT = 16;
  localparam int ROW_BITS_DEFAULT    = 13;
  localparam int MAX_COLUMNS_DEFAULT = 4096;

  // Register reset values
  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET   = 24'd2;
  localparam logic [COLS_W-1:0]  COLUMN_COUNT_RESET   = 13'd1;
  localparam logic [GAIN_W-1:0]  GAIN_RESET           = 16'd256;
  localparam logic [AREA_W-1:0]  TOP_ROW_RESET        = 12'd0;
  localparam logic [AREA_W-1:0]  AREA_HEIGHT_RESET    = 12'd1;
  localparam logic [GRID_W-1:0]  GRID_DIVISIONS_RESET = 9'd0;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN           = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP_ROW        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_AREA_HEIGHT    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_DIVISIONS = 3'd5;

  // Columns emitted at most per frame
  localparam logic [1:0] MAX_EMITS = 2'd2;

  typedef enum logic [3:0] {
    ST_DIV_EDGE_GO,
    ST_DIV_EDGE_WAIT,
    ST_DIV_GRID_GO,
    ST_DIV_GRID_WAIT,
    ST_IDLE,
    ST_PRE,
    ST_POST,
    ST_GAIN_HI,
    ST_HALF_HI,
    ST_ROW_HI,
    ST_GAIN_LO,
    ST_HALF_LO,
    ST_ROW_LO,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic div_start;
    logic div_grid;
    logic store_edge;
    logic store_grid;
    logic restart;
    logic capture;
    logic update;
    logic finish;
    logic mul_gain;
    logic mul_half;
    logic row_hi;
    logic row_lo;
    logic load;
    logic sel_lo;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic due_now;
    logic due_next;
    logic out_free;
    logic cfg_write;
  } status_t;

endpackage

// ----- src/wpd_divider.sv -----
// Restoring divider, one quotient bit per cycle.
module wpd_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [wpd_pkg::COUNT_W-1:0]  dividend,
  input  logic [wpd_pkg::COLS_W-1:0]   divisor,
  output logic                         busy,
  output logic [wpd_pkg::COUNT_W-1:0]  quotient,
  output logic [wpd_pkg::COLS_W-1:0]   remainder
);

  localparam int CNT_W = $clog2(wpd_pkg::COUNT_W + 1);

  logic [CNT_W-1:0]            count;
  logic [wpd_pkg::COLS_W:0]    trial;
  logic [wpd_pkg::COLS_W:0]    diff;
  logic                        fits;

  assign trial = {remainder, quotient[wpd_pkg::COUNT_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_W'(wpd_pkg::COUNT_W);
    end else if (busy) begin
      count <= count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[wpd_pkg::COUNT_W-2:0], fits};
      remainder <= fits ? diff[wpd_pkg::COLS_W-1:0] : trial[wpd_pkg::COLS_W-1:0];
    end
  end

endmodule

// ----- src/wpd_datapath.sv -----
// Datapath: registers, bucket tracking, scaling multiplies and output register.
module wpd_datapath #(
  parameter int SAMPLE_BITS = wpd_pkg::SAMPLE_BITS_DEFAULT,
  parameter int ROW_BITS    = wpd_pkg::ROW_BITS_DEFAULT,
  parameter int MAX_COLUMNS = wpd_pkg::MAX_COLUMNS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  wpd_pkg::cmd_t                        cmd,
  output wpd_pkg::status_t                     status,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wpd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [wpd_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]        left_sample,
  input  logic                                 frame_last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [$clog2(MAX_COLUMNS)-1:0]       column,
  output logic [ROW_BITS-1:0]                  upper_row,
  output logic [ROW_BITS-1:0]                  lower_row,
  output logic                                 grid_mark,
  output logic                                 column_last
);

  localparam int COUNT_W = wpd_pkg::COUNT_W;
  localparam int COLS_W  = wpd_pkg::COLS_W;
  localparam int RC_W    = wpd_pkg::ROWCALC_W;
  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int HALF_W  = wpd_pkg::AREA_W - 1;
  localparam int MAG_W   = SAMPLE_BITS;
  localparam int P1_W    = MAG_W + wpd_pkg::GAIN_W;
  localparam int P2_W    = P1_W + HALF_W;
  localparam int SHIFT   = SAMPLE_BITS - 1 + wpd_pkg::GAIN_FRAC_BITS;
  localparam int SCL_W   = P2_W - SHIFT + 1;

  // Configuration registers
  logic [COUNT_W-1:0]               sample_count;
  logic [COLS_W-1:0]                column_count;
  logic [wpd_pkg::GAIN_W-1:0]       gain;
  logic [wpd_pkg::AREA_W-1:0]       top_row;
  logic [wpd_pkg::AREA_W-1:0]       area_height;
  logic [wpd_pkg::GRID_W-1:0]       grid_divisions;
  logic                             cfg_known;

  // Divider results
  logic [COUNT_W-1:0]               q0;
  logic [COLS_W-1:0]                r0;
  logic [COUNT_W-1:0]               grid_step;
  logic                             div_busy;
  logic [COUNT_W-1:0]               div_dividend;
  logic [COLS_W-1:0]                div_divisor;
  logic [COUNT_W-1:0]               div_quotient;
  logic [COLS_W-1:0]                div_remainder;

  // Stream state
  logic [COUNT_W-1:0]               frame;
  logic [COLS_W-1:0]                col;
  logic [COUNT_W:0]                 bound_q;
  logic [COLS_W-1:0]                bound_r;
  logic signed [SAMPLE_BITS-1:0]    peak_high;
  logic signed [SAMPLE_BITS-1:0]    peak_low;
  logic                             grid_seen;
  logic [COUNT_W-1:0]               grid_phase;
  logic signed [SAMPLE_BITS-1:0]    sample;
  logic                             sample_last;

  // Scaling
  logic [P1_W-1:0]                  prod_gain;
  logic [P2_W-1:0]                  prod_half;
  logic [RC_W-1:0]                  row_hi;
  logic [RC_W-1:0]                  row_lo;

  // Combinational helpers
  logic                             active;
  logic                             col_open;
  logic [COUNT_W-1:0]               bucket_end;
  logic [COUNT_W:0]                 frame_plus;
  logic                             in_bucket;
  logic [COLS_W:0]                  r_sum;
  logic                             bound_wrap;
  logic [COLS_W-1:0]                bound_r_next;
  logic [COUNT_W:0]                 bound_q_next;
  logic [COUNT_W-1:0]               grid_phase_step;
  logic                             restart_now;
  logic [MAG_W-1:0]                 high_mag;
  logic [MAG_W-1:0]                 low_mag;
  logic [MAG_W-1:0]                 mag;
  logic [HALF_W-1:0]                half;
  logic [RC_W-1:0]                  centre;
  logic [RC_W-1:0]                  bottom_sum;
  logic [RC_W-1:0]                  bottom;
  logic [SCL_W-2:0]                 scaled_floor;
  logic                             frac_nz;
  logic [SCL_W-1:0]                 scaled_ceil;
  logic                             hi_clamp;
  logic                             lo_clamp;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_known = cfg_index inside {wpd_pkg::REG_SAMPLE_COUNT, wpd_pkg::REG_COLUMN_COUNT,
                                  wpd_pkg::REG_GAIN, wpd_pkg::REG_TOP_ROW,
                                  wpd_pkg::REG_AREA_HEIGHT, wpd_pkg::REG_GRID_DIVISIONS};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count   <= wpd_pkg::SAMPLE_COUNT_RESET;
      column_count   <= wpd_pkg::COLUMN_COUNT_RESET;
      gain           <= wpd_pkg::GAIN_RESET;
      top_row        <= wpd_pkg::TOP_ROW_RESET;
      area_height    <= wpd_pkg::AREA_HEIGHT_RESET;
      grid_divisions <= wpd_pkg::GRID_DIVISIONS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wpd_pkg::REG_SAMPLE_COUNT:   sample_count   <= cfg_data[COUNT_W-1:0];
        wpd_pkg::REG_COLUMN_COUNT:   column_count   <= cfg_data[COLS_W-1:0];
        wpd_pkg::REG_GAIN:           gain           <= cfg_data[wpd_pkg::GAIN_W-1:0];
        wpd_pkg::REG_TOP_ROW:        top_row        <= cfg_data[wpd_pkg::AREA_W-1:0];
        wpd_pkg::REG_AREA_HEIGHT:    area_height    <= cfg_data[wpd_pkg::AREA_W-1:0];
        wpd_pkg::REG_GRID_DIVISIONS: grid_divisions <= cfg_data[wpd_pkg::GRID_W-1:0];
        default: ;
      endcase
    end
  end

  // Shared divider for the bucket edge and the grid interval
  assign div_dividend = cmd.div_grid ? sample_count : sample_count - COUNT_W'(1);
  assign div_divisor  = cmd.div_grid ? COLS_W'(grid_divisions) : column_count;

  wpd_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  always_ff @(posedge clk) begin
    if (cmd.store_edge) begin
      q0 <= div_quotient;
      r0 <= div_remainder;
    end
    if (cmd.store_grid) begin
      grid_step <= (grid_divisions == '0) ? '0 : {div_quotient[COUNT_W-1:1], 1'b0};
    end
  end

  // Bucket tracking
  assign active     = (column_count != '0) && (32'(column_count) <= MAX_COLUMNS) &&
                      (sample_count >= COUNT_W'({column_count, 1'b0}));
  assign col_open   = active && (col < column_count);
  assign bucket_end = bound_q[COUNT_W:1];
  assign frame_plus = {1'b0, frame} + (COUNT_W+1)'(1);
  assign in_bucket  = col_open && (frame < bucket_end);

  assign r_sum        = {1'b0, bound_r} + {1'b0, r0};
  assign bound_wrap   = r_sum >= {1'b0, column_count};
  assign bound_r_next = bound_wrap ? COLS_W'(r_sum - {1'b0, column_count}) : r_sum[COLS_W-1:0];
  assign bound_q_next = bound_q + (COUNT_W+1)'(q0) + (COUNT_W+1)'(bound_wrap);

  assign grid_phase_step = grid_phase + COUNT_W'(2);
  assign restart_now     = cmd.restart || (cmd.finish && sample_last);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample      <= left_sample;
      sample_last <= frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame      <= '0;
      col        <= '0;
      bound_q    <= '0;
      bound_r    <= '0;
      peak_high  <= '0;
      peak_low   <= '0;
      grid_seen  <= 1'b0;
      grid_phase <= '0;
    end else if (restart_now) begin
      frame      <= '0;
      col        <= '0;
      bound_q    <= (COUNT_W+1)'(q0);
      bound_r    <= r0;
      peak_high  <= '0;
      peak_low   <= '0;
      grid_seen  <= 1'b0;
      grid_phase <= '0;
    end else if (cmd.load) begin
      col       <= col + COLS_W'(1);
      bound_q   <= bound_q_next;
      bound_r   <= bound_r_next;
      peak_high <= '0;
      peak_low  <= '0;
      grid_seen <= 1'b0;
    end else if (cmd.update) begin
      if (in_bucket) begin
        if (sample > peak_high) begin
          peak_high <= sample;
        end else if (sample <= peak_low) begin
          peak_low <= sample;
        end
        if ((grid_step != '0) && (frame != '0) && (grid_phase == '0)) begin
          grid_seen <= 1'b1;
        end
      end
    end else if (cmd.finish) begin
      if (frame != '1) begin
        frame      <= frame + COUNT_W'(1);
        grid_phase <= (grid_phase_step == grid_step) ? '0 : grid_phase_step;
      end
    end
  end

  // Peak scaling: magnitude * gain, then * half height, then round to rows
  assign high_mag = $unsigned(peak_high);
  assign low_mag  = $unsigned(~peak_low) + MAG_W'(1);
  assign mag      = cmd.sel_lo ? low_mag : high_mag;
  assign half     = area_height[wpd_pkg::AREA_W-1:1];

  always_ff @(posedge clk) begin
    if (cmd.mul_gain) begin
      prod_gain <= P1_W'(mag) * P1_W'(gain);
    end
    if (cmd.mul_half) begin
      prod_half <= P2_W'(prod_gain) * P2_W'(half);
    end
  end

  assign centre       = RC_W'(top_row) + RC_W'(half);
  assign bottom_sum   = RC_W'(top_row) + RC_W'(area_height);
  assign bottom       = (bottom_sum == '0) ? '0 : bottom_sum - RC_W'(1);
  assign scaled_floor = prod_half[P2_W-1:SHIFT];
  assign frac_nz      = |prod_half[SHIFT-1:0];
  assign scaled_ceil  = SCL_W'(scaled_floor) + SCL_W'(frac_nz);
  assign hi_clamp     = scaled_ceil > SCL_W'(half);
  assign lo_clamp     = (SCL_W'(scaled_floor) + SCL_W'(half)) >= SCL_W'(area_height);

  always_ff @(posedge clk) begin
    if (cmd.row_hi) begin
      row_hi <= hi_clamp ? RC_W'(top_row) : centre - RC_W'(scaled_ceil);
    end
    if (cmd.row_lo) begin
      row_lo <= lo_clamp ? bottom : centre + RC_W'(scaled_floor);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      column      <= COL_W'(col);
      upper_row   <= ROW_BITS'(row_hi);
      lower_row   <= ROW_BITS'(row_lo);
      grid_mark   <= grid_seen;
      column_last <= (col + COLS_W'(1)) == column_count;
    end
  end

  always_comb begin
    status.div_busy  = div_busy;
    status.due_now   = col_open && (bucket_end <= frame);
    status.due_next  = col_open && ({1'b0, bucket_end} <= frame_plus);
    status.out_free  = !out_valid || !out_stall;
    status.cfg_write = cfg_valid && cfg_ready && cfg_known;
  end

endmodule

// ----- src/wpd_ctrl.sv -----
// Controller state machine sequencing setup, frames and column emission.
module wpd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  wpd_pkg::status_t  status,
  output wpd_pkg::cmd_t     cmd
);

  wpd_pkg::state_t state;
  wpd_pkg::state_t state_next;
  logic            phase_post;
  logic [1:0]      emit_count;
  logic            emit_room;

  assign emit_room = emit_count != wpd_pkg::MAX_EMITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= wpd_pkg::ST_DIV_EDGE_GO;
      phase_post <= 1'b0;
      emit_count <= '0;
    end else begin
      state <= state_next;
      case (state)
        wpd_pkg::ST_IDLE: emit_count <= '0;
        wpd_pkg::ST_PRE:  phase_post <= 1'b0;
        wpd_pkg::ST_POST: phase_post <= 1'b1;
        wpd_pkg::ST_LOAD: begin
          if (status.out_free) begin
            emit_count <= emit_count + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      wpd_pkg::ST_DIV_EDGE_GO:   state_next = wpd_pkg::ST_DIV_EDGE_WAIT;
      wpd_pkg::ST_DIV_EDGE_WAIT: begin
        if (!status.div_busy) state_next = wpd_pkg::ST_DIV_GRID_GO;
      end
      wpd_pkg::ST_DIV_GRID_GO:   state_next = wpd_pkg::ST_DIV_GRID_WAIT;
      wpd_pkg::ST_DIV_GRID_WAIT: begin
        if (!status.div_busy) state_next = wpd_pkg::ST_IDLE;
      end
      wpd_pkg::ST_IDLE: begin
        if (in_valid) state_next = wpd_pkg::ST_PRE;
      end
      wpd_pkg::ST_PRE: begin
        state_next = (status.due_now && emit_room) ? wpd_pkg::ST_GAIN_HI : wpd_pkg::ST_POST;
      end
      wpd_pkg::ST_POST: begin
        state_next = (status.due_next && emit_room) ? wpd_pkg::ST_GAIN_HI : wpd_pkg::ST_IDLE;
      end
      wpd_pkg::ST_GAIN_HI: state_next = wpd_pkg::ST_HALF_HI;
      wpd_pkg::ST_HALF_HI: state_next = wpd_pkg::ST_ROW_HI;
      wpd_pkg::ST_ROW_HI:  state_next = wpd_pkg::ST_GAIN_LO;
      wpd_pkg::ST_GAIN_LO: state_next = wpd_pkg::ST_HALF_LO;
      wpd_pkg::ST_HALF_LO: state_next = wpd_pkg::ST_ROW_LO;
      wpd_pkg::ST_ROW_LO:  state_next = wpd_pkg::ST_LOAD;
      wpd_pkg::ST_LOAD: begin
        if (status.out_free) begin
          state_next = phase_post ? wpd_pkg::ST_POST : wpd_pkg::ST_PRE;
        end
      end
      default: state_next = wpd_pkg::ST_DIV_EDGE_GO;
    endcase
    if (status.cfg_write) begin
      state_next = wpd_pkg::ST_DIV_EDGE_GO;
    end
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      wpd_pkg::ST_DIV_EDGE_GO:   cmd.div_start = 1'b1;
      wpd_pkg::ST_DIV_EDGE_WAIT: cmd.store_edge = !status.div_busy;
      wpd_pkg::ST_DIV_GRID_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_grid  = 1'b1;
      end
      wpd_pkg::ST_DIV_GRID_WAIT: begin
        // Hold the grid divisor for the whole division
        cmd.div_grid   = 1'b1;
        cmd.store_grid = !status.div_busy;
        cmd.restart    = !status.div_busy;
      end
      wpd_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      wpd_pkg::ST_PRE:     cmd.update = !(status.due_now && emit_room);
      wpd_pkg::ST_POST:    cmd.finish = !(status.due_next && emit_room);
      wpd_pkg::ST_GAIN_HI: cmd.mul_gain = 1'b1;
      wpd_pkg::ST_HALF_HI: cmd.mul_half = 1'b1;
      wpd_pkg::ST_ROW_HI:  cmd.row_hi = 1'b1;
      wpd_pkg::ST_GAIN_LO: begin
        cmd.mul_gain = 1'b1;
        cmd.sel_lo   = 1'b1;
      end
      wpd_pkg::ST_HALF_LO: cmd.mul_half = 1'b1;
      wpd_pkg::ST_ROW_LO:  cmd.row_lo = 1'b1;
      wpd_pkg::ST_LOAD:    cmd.load = status.out_free;
      default: ;
    endcase
  end

endmodule

// ----- src/waveform_peak_decimator.sv -----
// Top level of the waveform min/max peak decimator for column display.
//
// Frames stream in on the input channel (in_valid / in_stall), one left sample
// per transaction; frame_last closes the waveform and restarts the count.
// Finished columns leave on the output channel (out_valid / out_stall) with
// their index, the two screen rows of the positive and negative peaks, the
// grid flag and a flag on the final column.
// Registers are written on the configuration channel (cfg_valid / cfg_ready,
// always ready); every write to a known index restarts the stream.
// Each frame passes IDLE, PRE and POST, and in_stall is low only in IDLE; each
// column that the frame closes (at most two per frame) adds the shared multiplier
// sequence GAIN_HI, HALF_HI, ROW_HI, GAIN_LO, HALF_LO, ROW_LO and then LOAD.
// LOAD registers the column into the output register; receiver stalls hold
// the block in LOAD while the register still holds an untaken column.
// Reset and each register write start a setup in which two serial divisions
// (one bit per cycle) find the column step and the grid interval; in_stall
// stays high during that time.
// While the receiver stalls, one column waits in the output register and the
// block keeps taking frames until it has a second column to hand over.
module waveform_peak_decimator #(
  parameter int SAMPLE_BITS = wpd_pkg::SAMPLE_BITS_DEFAULT,
  parameter int ROW_BITS    = wpd_pkg::ROW_BITS_DEFAULT,
  parameter int MAX_COLUMNS = wpd_pkg::MAX_COLUMNS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [wpd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [SAMPLE_BITS-1:0]      left_sample,
  input  logic                               frame_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [$clog2(MAX_COLUMNS)-1:0]     column,
  output logic [ROW_BITS-1:0]                upper_row,
  output logic [ROW_BITS-1:0]                lower_row,
  output logic                               grid_mark,
  output logic                               column_last
);

`include "waveform_peak_decimator_defines.svh"

  wpd_pkg::cmd_t    cmd;
  wpd_pkg::status_t status;

  // Sequence setup, frame handling and column emission
  wpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold registers, bucket bounds, peaks, scaling and the output register
  wpd_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ROW_BITS    (ROW_BITS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .left_sample (left_sample),
    .frame_last  (frame_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .column      (column),
    .upper_row   (upper_row),
    .lower_row   (lower_row),
    .grid_mark   (grid_mark),
    .column_last (column_last)
  );

  // No frame may enter while the bucket step or grid interval is being worked out
  `WPD_ASSERT_IMPLY(a_setup_stall, clk, rst, status.div_busy, in_stall, "frame in setup")
  // A column must never overwrite one that the receiver has not taken
  `WPD_ASSERT_IMPLY(a_load_free, clk, rst, cmd.load, (!out_valid || !out_stall), "column lost")
  // A register write must drop the block into setup
  `WPD_ASSERT_NEXT(a_cfg_setup, clk, rst, status.cfg_write, in_stall, "no setup after write")

endmodule
